// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication sampled on the rising clock edge, off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed: label");

// Condition that must hold at every sampled edge, off while reset is low.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: label");

`endif

// File: sv/rgb2hsl_pkg.sv
`default_nettype none
package rgb2hsl_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned QUO_W = 8;
  localparam int unsigned DEN_W = 11;
  localparam int unsigned REM_W = DEN_W + QUO_W;

  typedef struct packed {
    logic [REM_W-1:0] hue_num;
    logic [DEN_W-1:0] hue_den;
    logic [REM_W-1:0] sat_num;
    logic [DEN_W-1:0] sat_den;
    logic [PIX_W-1:0] light;
  } prep_t;

endpackage
`default_nettype wire

// File: sv/rgb2hsl_prep.sv
`default_nettype none
module rgb2hsl_prep (
  input  logic [rgb2hsl_pkg::PIX_W-1:0] red_i,
  input  logic [rgb2hsl_pkg::PIX_W-1:0] green_i,
  input  logic [rgb2hsl_pkg::PIX_W-1:0] blue_i,
  output rgb2hsl_pkg::prep_t            prep_o
);

  logic [7:0]  mx, mn, d;
  logic [8:0]  sum, sden;
  logic [10:0] num, d11;
  logic [15:0] d255;
  logic [18:0] num255;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
    d   = mx - mn;
    d11 = {3'b000, d};
    sum = {1'b0, mx} + {1'b0, mn};
    sden = (sum <= 9'd255) ? sum : (9'd510 - sum);
    if (mx == red_i) begin
      if (green_i < blue_i) num = 11'd6 * d11 - {3'b000, blue_i - green_i};
      else                  num = {3'b000, green_i - blue_i};
    end else if (mx == green_i) begin
      num = 11'd2 * d11 + {3'b000, blue_i} - {3'b000, red_i};
    end else begin
      num = 11'd4 * d11 + {3'b000, red_i} - {3'b000, green_i};
    end
    d255   = {d, 8'h00} - {8'h00, d};
    num255 = {num, 8'h00} - {8'h00, num};
    if (d == 8'd0) begin
      prep_o.hue_num = '0;
      prep_o.hue_den = 11'd1;
      prep_o.sat_num = '0;
      prep_o.sat_den = 11'd1;
    end else begin
      prep_o.hue_num = num255;
      prep_o.hue_den = 11'd6 * d11;
      prep_o.sat_num = {3'b000, d255};
      prep_o.sat_den = {2'b00, sden};
    end
    prep_o.light = (sum > 9'd255) ? 8'(sum - 9'd255) : 8'd0;
  end

endmodule
`default_nettype wire

// File: sv/rgb2hsl_div_cell.sv
`default_nettype none
module rgb2hsl_div_cell (
  input  logic                           clk_i,
  input  logic [rgb2hsl_pkg::REM_W-1:0]  rem_i,
  input  logic [rgb2hsl_pkg::REM_W-1:0]  div_i,
  input  logic [rgb2hsl_pkg::QUO_W-1:0]  quo_i,
  output logic [rgb2hsl_pkg::REM_W-1:0]  rem_o,
  output logic [rgb2hsl_pkg::REM_W-1:0]  div_o,
  output logic [rgb2hsl_pkg::QUO_W-1:0]  quo_o
);

  logic                          ge;
  logic [rgb2hsl_pkg::REM_W-1:0] rem_d, rem_q, div_q;
  logic [rgb2hsl_pkg::QUO_W-1:0] quo_q;

  assign ge    = rem_i >= div_i;
  assign rem_d = ge ? rem_i - div_i : rem_i;

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_i >> 1;
    quo_q <= {quo_i[rgb2hsl_pkg::QUO_W-2:0], ge};
  end

  assign rem_o = rem_q;
  assign div_o = div_q;
  assign quo_o = quo_q;

endmodule
`default_nettype wire

// File: sv/rgb_to_hsl_packed_top.sv
// Result strobe done_o follows the start transfer through one prep stage,
// then one restoring-division cell per quotient bit.
// Throughput: one pixel per clock; busy_o stays low, the receiver cannot stall.
// Reset: rst_ni low clears the valid line asynchronously; no result is shown.
`default_nettype none
module rgb_to_hsl_packed_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rgb2hsl_pkg::PIX_W-1:0] red_i,
  input  logic [rgb2hsl_pkg::PIX_W-1:0] green_i,
  input  logic [rgb2hsl_pkg::PIX_W-1:0] blue_i,
  output logic                          done_o,
  output logic [rgb2hsl_pkg::PIX_W-1:0] hue_code_o,
  output logic [rgb2hsl_pkg::PIX_W-1:0] sat_code_o,
  output logic [rgb2hsl_pkg::PIX_W-1:0] light_code_o
);

  localparam int unsigned NC = rgb2hsl_pkg::QUO_W;
  localparam int unsigned RW = rgb2hsl_pkg::REM_W;

  rgb2hsl_pkg::prep_t prep;

  logic [RW-1:0]                   h_rem [NC+1];
  logic [RW-1:0]                   h_div [NC+1];
  logic [NC-1:0]                   h_quo [NC+1];
  logic [RW-1:0]                   s_rem [NC+1];
  logic [RW-1:0]                   s_div [NC+1];
  logic [NC-1:0]                   s_quo [NC+1];
  logic [rgb2hsl_pkg::PIX_W-1:0]   light_q [NC+1];
  logic [NC:0]                     vld_q, vld_d;

  rgb2hsl_prep u_prep (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .prep_o  (prep)
  );

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[NC-1:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // divisor starts aligned to the top quotient bit
  always_ff @(posedge clk_i) begin
    h_rem[0]   <= prep.hue_num;
    h_div[0]   <= {1'b0, prep.hue_den, {(NC-1){1'b0}}};
    h_quo[0]   <= '0;
    s_rem[0]   <= prep.sat_num;
    s_div[0]   <= {1'b0, prep.sat_den, {(NC-1){1'b0}}};
    s_quo[0]   <= '0;
    light_q[0] <= prep.light;
    for (int i = 1; i <= NC; i++) light_q[i] <= light_q[i-1];
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    rgb2hsl_div_cell u_hue (
      .clk_i (clk_i),
      .rem_i (h_rem[k]),   .div_i (h_div[k]),   .quo_i (h_quo[k]),
      .rem_o (h_rem[k+1]), .div_o (h_div[k+1]), .quo_o (h_quo[k+1])
    );
    rgb2hsl_div_cell u_sat (
      .clk_i (clk_i),
      .rem_i (s_rem[k]),   .div_i (s_div[k]),   .quo_i (s_quo[k]),
      .rem_o (s_rem[k+1]), .div_o (s_div[k+1]), .quo_o (s_quo[k+1])
    );
  end

  assign done_o       = vld_q[NC];
  assign hue_code_o   = h_quo[NC];
  assign sat_code_o   = s_quo[NC];
  assign light_code_o = light_q[NC];

endmodule
`default_nettype wire

// File: sv/rgb2hsl_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rgb2hsl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       done_o,
  input logic [7:0] hue_code_o,
  input logic [7:0] sat_code_o,
  input logic [7:0] light_code_o
);

  logic xfer, gray, dark;
  assign xfer = start_i && !busy_o;
  assign gray = (red_i == green_i) && (green_i == blue_i);
  assign dark = !red_i[7] && !green_i[7] && !blue_i[7];

  `ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o)
  `ASSERT_IMPL(a_latency, clk_i, rst_ni, xfer, ##9 done_o)
  `ASSERT_IMPL(a_gray_zero, clk_i, rst_ni, xfer && gray, ##9 (hue_code_o == 8'd0 && sat_code_o == 8'd0))
  `ASSERT_IMPL(a_dark_light, clk_i, rst_ni, xfer && dark, ##9 (light_code_o == 8'd0))

endmodule

bind rgb_to_hsl_packed_top rgb2hsl_checker u_rgb2hsl_checker (.*);
`default_nettype wire

// File: tb/rgb_to_hsl_packed_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module rgb_to_hsl_packed_top_tb;

  typedef struct packed {
    logic [rgb2hsl_pkg::PIX_W-1:0] hue;
    logic [rgb2hsl_pkg::PIX_W-1:0] sat;
    logic [rgb2hsl_pkg::PIX_W-1:0] light;
  } hsl_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [rgb2hsl_pkg::PIX_W-1:0] red_i = '0;
  logic [rgb2hsl_pkg::PIX_W-1:0] green_i = '0;
  logic [rgb2hsl_pkg::PIX_W-1:0] blue_i = '0;
  logic busy_o, done_o;
  logic [rgb2hsl_pkg::PIX_W-1:0] hue_code_o, sat_code_o, light_code_o;

  hsl_t hsl_expected_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;

  rgb_to_hsl_packed_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .red_i(red_i), .green_i(green_i), .blue_i(blue_i), .done_o(done_o),
    .hue_code_o(hue_code_o), .sat_code_o(sat_code_o), .light_code_o(light_code_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic hsl_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned mx, mn, sum, d, num;
    hsl_t res;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    sum = mx + mn;
    res = '0;
    if (mx != mn) begin
      d = mx - mn;
      if (sum <= 255) res.sat = 8'((255 * d) / sum);
      else res.sat = 8'((255 * d) / (510 - sum));
      if (mx == r) num = (g < b) ? 6 * d - (b - g) : g - b;
      else if (mx == g) num = 2 * d + b - r;
      else num = 4 * d + r - g;
      res.hue = 8'((255 * num) / (6 * d));
    end
    if (sum > 255) res.light = 8'(sum - 255);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, exp, cycle_cnt);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    hsl_t exp;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (hsl_expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        exp = hsl_expected_q.pop_front();
        if (hue_code_o !== exp.hue) report_mismatch("hue", hue_code_o, exp.hue);
        if (sat_code_o !== exp.sat) report_mismatch("sat", sat_code_o, exp.sat);
        if (light_code_o !== exp.light) report_mismatch("light", light_code_o, exp.light);
      end
    end
  end

  // Drives one pixel; holds start high across back-to-back transfers.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (busy_o);
    hsl_expected_q.push_back(convert_pixel(r, g, b));
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(127, 128, 127);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 0, 1);
    send_pixel(255, 1, 0);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(255, 254, 254);
    send_pixel(1, 0, 0);
    send_pixel(200, 55, 10);
    send_pixel(200, 56, 10);
    send_pixel(10, 20, 245);
    send_pixel(170, 85, 170);
    send_pixel(254, 1, 127);
  endtask

  task automatic test_random(int unsigned n, int unsigned pct);
    logic [7:0] r, g, b;
    idle_pct = pct;
    repeat (n) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(4))
        0: g = r;
        1: b = $urandom_range(1) ? r : g;
        2: begin g = r; b = r; end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350, 0);
    test_random(330, 62);
    test_random(330, 62);
    test_random(340, 34);
    start_i <= 1'b0;
    while (hsl_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
